@@ rtl/core/zcn_pkg.sv @@
package zcn_pkg;

  localparam int MaxSamples = 64;
  localparam int AddrW = $clog2(MaxSamples);
  localparam int CntW = AddrW + 1;
  localparam int SumW = 38;
  localparam int DevW = 33;
  localparam int SqW = 64;
  localparam int StdW = 32;
  localparam int DataW = 32;
  localparam logic [StdW-1:0] OneQ16 = 32'd65536;

  localparam int StW = 4;
  localparam logic [StW-1:0] StLoad    = 4'd0;
  localparam logic [StW-1:0] StMean    = 4'd1;
  localparam logic [StW-1:0] StSqRd    = 4'd2;
  localparam logic [StW-1:0] StSqMul   = 4'd3;
  localparam logic [StW-1:0] StVar     = 4'd4;
  localparam logic [StW-1:0] StSqrt    = 4'd5;
  localparam logic [StW-1:0] StOutRd   = 4'd6;
  localparam logic [StW-1:0] StOutDiv  = 4'd7;
  localparam logic [StW-1:0] StOutHold = 4'd8;
  localparam logic [StW-1:0] StSqAcc   = 4'd9;
  localparam logic [StW-1:0] StOutPrep = 4'd10;

endpackage

@@ rtl/core/zscore_column_normalizer_core.sv @@
// Z-score standardizer for one column of up to 64 signed Q16.16 samples. Words
// are loaded one per cycle; the word with last_sample_i set closes the column,
// and words past the 64th are dropped. The block then computes the mean (bit-serial
// divider), the sum of squared deviations (a shift-add square per sample), the
// sample variance (bit-serial divider) and a 35-step bit-serial square root. It
// then emits one Q8.24 result per stored sample, each from a bit-serial restoring
// division followed by setup and hand-off. A single-sample column skips the
// variance division and the root and uses a standard deviation of one.
// No word is taken while a column is being computed or emitted.
module zscore_column_normalizer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          sample_valid_i,
  output logic                          sample_stall_o,
  input  logic signed [31:0]            sample_value_i,
  input  logic                          last_sample_i,
  output logic                          result_valid_o,
  input  logic                          result_stall_i,
  output logic signed [31:0]            normalized_value_o,
  output logic                          last_result_o
);
  import zcn_pkg::*;

  logic [DataW-1:0] mem_q [MaxSamples];
  logic [DataW-1:0] rd_q;

  logic [StW-1:0]   state_q;
  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  idx_q;
  logic signed [SumW-1:0] sum_q;
  logic signed [DevW-1:0] mean_q;
  logic [SqW-1:0]   sqsum_q;
  logic [StdW-1:0]  std_q;
  logic [6:0]       step_q;
  // Shared bit-serial divider / root registers
  logic [SqW-1:0]   num_q;   // dividend shifting out MSB first
  logic [SqW:0]     rem_q;
  logic [SqW-1:0]   quo_q;
  logic             neg_q;
  logic [SqW-1:0]   prod_q;
  logic [DevW-1:0]  mag_q;
  logic signed [DataW-1:0] res_q;
  logic             res_last_q;
  logic             res_valid_q;

  logic accept_in;
  assign sample_stall_o = (state_q != StLoad);
  assign accept_in = sample_valid_i && (state_q == StLoad);

  // Deviation of the word just read from the mean
  logic signed [DevW-1:0] dev;
  logic [DevW-1:0] dev_mag;
  assign dev = DevW'($signed(rd_q)) - mean_q;
  assign dev_mag = dev[DevW-1] ? DevW'(-dev) : DevW'(dev);

  // One restoring division step
  logic [SqW:0] rem_sh;
  logic [SqW:0] den_ext;
  logic         fits;
  always_comb begin
    rem_sh = {rem_q[SqW-1:0], num_q[SqW-1]};
    den_ext = '0;
    case (state_q)
      StMean:   den_ext = (SqW+1)'(count_q);
      StVar:    den_ext = (SqW+1)'(count_q - CntW'(1));
      StOutDiv: den_ext = (SqW+1)'(std_q);
      default:  den_ext = '0;
    endcase
    fits = (rem_sh >= den_ext);
  end

  // One square root step: trial = (root << 2 | 1) against remainder
  logic [35:0] sq_rem_sh;
  logic [35:0] sq_trial;
  assign sq_rem_sh = {rem_q[33:0], num_q[SqW-1 -: 2]};
  assign sq_trial  = {quo_q[33:0], 2'b01};

  // Rounding and saturation of the output quotient (quotient carries one extra bit)
  logic [SqW-1:0] q_rnd;
  logic signed [DataW-1:0] sat_val;
  always_comb begin
    q_rnd = (quo_q + SqW'(1)) >> 1;
    if (neg_q) begin
      sat_val = (q_rnd > SqW'(64'h8000_0000)) ? 32'sh8000_0000 : DataW'(-q_rnd);
    end else begin
      sat_val = (q_rnd > SqW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : DataW'(q_rnd);
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (accept_in && count_q < CntW'(MaxSamples)) begin
      mem_q[count_q[AddrW-1:0]] <= sample_value_i;
    end
    rd_q <= mem_q[idx_q[AddrW-1:0]];
  end

  logic [SumW-1:0] sum_mag;
  assign sum_mag = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      count_q     <= '0;
      idx_q       <= '0;
      sum_q       <= '0;
      mean_q      <= '0;
      sqsum_q     <= '0;
      std_q       <= OneQ16;
      step_q      <= '0;
      num_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      neg_q       <= 1'b0;
      prod_q      <= '0;
      mag_q       <= '0;
      res_q       <= '0;
      res_last_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      // Drop the output word once taken
      if (res_valid_q && !result_stall_i) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        StLoad: begin
          if (accept_in) begin
            if (count_q < CntW'(MaxSamples)) begin
              count_q <= count_q + CntW'(1);
              sum_q   <= sum_q + SumW'(sample_value_i);
            end
            if (last_sample_i) begin
              // Start mean division: |sum| + n/2 by n
              state_q <= StMean;
              step_q  <= 7'd0;
              rem_q   <= '0;
              quo_q   <= '0;
            end
          end
          if (accept_in && last_sample_i) begin
            if (count_q < CntW'(MaxSamples)) begin
              neg_q <= (sum_q + SumW'(sample_value_i)) < 0;
              num_q <= {26'd0, ((sum_q + SumW'(sample_value_i)) < 0)
                       ? SumW'(-(sum_q + SumW'(sample_value_i)))
                       : SumW'(sum_q + SumW'(sample_value_i))} +
                       SqW'((count_q + CntW'(1)) >> 1);
            end else begin
              neg_q <= sum_q[SumW-1];
              num_q <= {26'd0, sum_mag} + SqW'(count_q >> 1);
            end
          end
        end
        StMean: begin
          // Shift the dividend up to the top, then advance one quotient bit per step
          if (step_q < 7'd26) begin
            num_q  <= {num_q[SqW-2:0], 1'b0};
            step_q <= step_q + 7'd1;
          end else begin
            rem_q  <= fits ? rem_sh - den_ext : rem_sh;
            quo_q  <= {quo_q[SqW-2:0], fits};
            num_q  <= {num_q[SqW-2:0], 1'b0};
            step_q <= step_q + 7'd1;
            if (step_q == 7'd63) begin
              mean_q  <= neg_q ? DevW'(-{quo_q[DevW-2:0], fits})
                               : DevW'({quo_q[DevW-2:0], fits});
              sqsum_q <= '0;
              idx_q   <= '0;
              state_q <= StSqRd;
            end
          end
        end
        StSqRd: begin
          // Wait for registered read
          if (idx_q == count_q) begin
            state_q <= StVar;
            step_q  <= '0;
            rem_q   <= '0;
            quo_q   <= '0;
            num_q   <= sqsum_q + SqW'((count_q - CntW'(1)) >> 1);
            if (count_q < CntW'(2)) begin
              std_q   <= OneQ16;
              idx_q   <= '0;
              state_q <= StOutRd;
            end
          end else begin
            state_q <= StSqMul;
          end
        end
        StSqMul: begin
          // Load the shift-add square of |d|
          mag_q   <= dev_mag;
          num_q   <= SqW'(dev_mag);
          prod_q  <= '0;
          step_q  <= '0;
          state_q <= StSqAcc;
        end
        StSqAcc: begin
          // Add the shifted multiplicand for each set multiplier bit
          if (mag_q[0]) begin
            prod_q <= prod_q + num_q;
          end
          num_q <= {num_q[SqW-2:0], 1'b0};
          mag_q <= mag_q >> 1;
          if (step_q == 7'd31) begin
            step_q  <= '0;
            state_q <= StOutHold;
          end else begin
            step_q <= step_q + 7'd1;
          end
        end
        StOutHold: begin
          if (step_q == 7'd0) begin
            // Square accumulate stage
            sqsum_q <= sqsum_q + ((prod_q + 64'd32) >> 6);
            idx_q   <= idx_q + CntW'(1);
            state_q <= StSqRd;
          end else if (!res_valid_q || !result_stall_i) begin
            res_valid_q <= 1'b1;
            res_q       <= sat_val;
            res_last_q  <= (idx_q + CntW'(1) == count_q);
            idx_q       <= idx_q + CntW'(1);
            step_q      <= '0;
            state_q     <= (idx_q + CntW'(1) == count_q) ? StLoad : StOutRd;
            if (idx_q + CntW'(1) == count_q) begin
              count_q <= '0;
              sum_q   <= '0;
            end
          end
        end
        StVar: begin
          rem_q  <= fits ? rem_sh - den_ext : rem_sh;
          quo_q  <= {quo_q[SqW-2:0], fits};
          num_q  <= {num_q[SqW-2:0], 1'b0};
          step_q <= step_q + 7'd1;
          if (step_q == 7'd63) begin
            // Root of var << 6: 70-bit operand taken two bits a step
            num_q   <= {quo_q[SqW-2:0], fits} << 2;
            rem_q   <= (SqW+1)'({quo_q[SqW-2:0], fits} >> 62);
            quo_q   <= '0;
            step_q  <= '0;
            state_q <= StSqrt;
          end
        end
        StSqrt: begin
          if (step_q == 7'd0) begin
            // First pair already in rem_q
            if (rem_q[35:0] >= 36'd1) begin
              rem_q <= rem_q - (SqW+1)'(1);
              quo_q <= 64'd1;
            end else begin
              quo_q <= '0;
            end
            step_q <= 7'd1;
          end else begin
            if (sq_rem_sh >= sq_trial) begin
              rem_q <= (SqW+1)'(sq_rem_sh - sq_trial);
              quo_q <= {quo_q[SqW-2:0], 1'b1};
            end else begin
              rem_q <= (SqW+1)'(sq_rem_sh);
              quo_q <= {quo_q[SqW-2:0], 1'b0};
            end
            num_q  <= {num_q[SqW-3:0], 2'b00};
            step_q <= step_q + 7'd1;
            if (step_q == 7'd34) begin
              std_q   <= '0;
              state_q <= StOutPrep;
            end
          end
        end
        StOutPrep: begin
          // Round root: remainder above root means add one
          if (rem_q[35:0] > 36'(quo_q[33:0])) begin
            std_q <= (quo_q[StdW-1:0] + 32'd1 == 32'd0) ? OneQ16 : quo_q[StdW-1:0] + 32'd1;
          end else begin
            std_q <= (quo_q[StdW-1:0] == 32'd0) ? OneQ16 : quo_q[StdW-1:0];
          end
          idx_q   <= '0;
          state_q <= StOutRd;
        end
        StOutRd: begin
          state_q <= StOutDiv;
          step_q  <= 7'd127;
        end
        StOutDiv: begin
          if (step_q == 7'd127) begin
            // Load |d| at the top; 57 steps give |d| * 2^25 / std
            neg_q  <= dev[DevW-1];
            num_q  <= {dev_mag[31:0], 32'd0};
            rem_q  <= '0;
            quo_q  <= '0;
            step_q <= '0;
          end else begin
            rem_q  <= fits ? rem_sh - den_ext : rem_sh;
            quo_q  <= {quo_q[SqW-2:0], fits};
            num_q  <= {num_q[SqW-2:0], 1'b0};
            step_q <= step_q + 7'd1;
            if (step_q == 7'd56) begin
              // Rounding bit: compare doubled remainder with std
              quo_q   <= {quo_q[SqW-2:0], fits};
              state_q <= StOutHold;
              step_q  <= 7'd1;
              num_q   <= '0;
            end
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  assign result_valid_o     = res_valid_q;
  assign normalized_value_o = res_q;
  assign last_result_o      = res_last_q;

endmodule
